// File: hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Types, codes and fixed formats shared by the ADSR envelope gain block.
// ----------------------------------------------------------------------------
package adsr_pkg;

	// Fixed formats: level Q1.30 (kept in [0, 1.0]), step signed Q2.30,
	// sustain Q1.15, gain Q4.12, gain-times-level factor Q4.16.
	localparam int LVL_W   = 31;
	localparam int STEP_W  = 32;
	localparam int FRM_W   = 24;
	localparam int SUS_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int FACT_W  = 20;
	localparam int GPROD_W = LVL_W + GAIN_W;
	localparam int ACT_W   = 2;
	localparam int PH_W    = 3;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 24;
	localparam int CNT_W   = $clog2(LVL_W);

	localparam logic [LVL_W-1:0]   LEVEL_ONE  = LVL_W'(1) << 30;
	localparam logic [LVL_W-1:0]   LEVEL_ZERO = '0;
	localparam logic [FRM_W-1:0]   FRM_MAX    = '1;
	localparam logic [SUS_W-1:0]   SUS_ONE    = 16'h8000;
	localparam logic [GPROD_W-1:0] GPROD_RND  = GPROD_W'(1) << 25;
	localparam int                 FACT_LSB   = 26;
	localparam int                 SMP_SHIFT  = 16;

	// Action codes carried in tuser
	localparam logic [ACT_W-1:0] ACT_FRAME    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd0;
	localparam logic [IDX_W-1:0] REG_DECAY   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SUSTAIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_RELEASE = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN    = 3'd4;

	// Register reset values
	localparam logic [FRM_W-1:0]  RST_ATTACK  = 24'd480;
	localparam logic [FRM_W-1:0]  RST_DECAY   = 24'd4800;
	localparam logic [SUS_W-1:0]  RST_SUSTAIN = 16'd16384;
	localparam logic [FRM_W-1:0]  RST_RELEASE = 24'd4800;
	localparam logic [GAIN_W-1:0] RST_GAIN    = 16'd4096;

	typedef enum logic [PH_W-1:0] {
		PH_SILENT  = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_DIV,
		ST_GAIN,
		ST_FACT,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [FRM_W-1:0]  attack_frames;
		logic [FRM_W-1:0]  decay_frames;
		logic [SUS_W-1:0]  sus_level;
		logic [FRM_W-1:0]  release_frames;
		logic [GAIN_W-1:0] linear_gain;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul_en;
	} lane_ctl_t;

	typedef struct packed {
		logic   out_load;
		phase_t phase;
	} out_ctl_t;

endpackage

// File: hdl/adsr_div.sv
// ----------------------------------------------------------------------------
// adsr_div
// Serial signed divider for the ramp step, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module adsr_div
	import adsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [STEP_W-1:0] dividend,
	input  logic [FRM_W-1:0]         divisor,
	output logic                     busy,
	output logic                     done,
	output logic signed [STEP_W-1:0] quotient
);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic [LVL_W-1:0]        dq_q;
	logic [FRM_W-1:0]        rem_q;
	logic [FRM_W-1:0]        dvs_q;
	logic [STEP_W-1:0]       mag;
	logic [FRM_W:0]          trial;
	logic [FRM_W:0]          diff;
	logic                    fits;

	assign mag   = dividend[STEP_W-1] ? STEP_W'(-dividend) : dividend;
	assign trial = {rem_q, dq_q[LVL_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(LVL_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[STEP_W-1];
			dq_q  <= mag[LVL_W-1:0];
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[FRM_W-1:0] : trial[FRM_W-1:0];
			dq_q  <= {dq_q[LVL_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

endmodule

// File: hdl/adsr_lane.sv
// ----------------------------------------------------------------------------
// adsr_lane
// One channel lane: sample times envelope factor, round, saturate.
// ----------------------------------------------------------------------------
module adsr_lane
	import adsr_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
)
(
	input  logic                          clk,
	input  lane_ctl_t                     ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [FACT_W-1:0]             factor,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PW = SAMPLE_BITS + FACT_W + 1;
	localparam int RW = PW - SMP_SHIFT;

	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [PW-1:0]          prod_s1;
	logic signed [PW-1:0]          rnd;
	logic [RW-1:0]                 shr;
	logic [RW-SAMPLE_BITS:0]       hi;

	always_ff @(posedge clk) begin
		if (ctl.load)
			smp_q <= sample_in;
		if (ctl.mul_en)
			prod_s1 <= PW'(smp_q * $signed({1'b0, factor}));
	end

	// Floor shift after adding half an LSB; saturate when the upper bits
	// are not a plain sign extension.
	assign rnd = prod_s1 + PW'(1 << (SMP_SHIFT - 1));
	assign shr = rnd[PW-1:SMP_SHIFT];
	assign hi  = shr[RW-1:SAMPLE_BITS-1];

	always_comb begin
		if ((&hi) || !(|hi))
			result = shr[SAMPLE_BITS-1:0];
		else if (shr[RW-1])
			result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	end

endmodule

// File: hdl/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// adsr_ctrl
// Envelope sequencer: phase, elapsed count, level and step, gain factor.
// ----------------------------------------------------------------------------
module adsr_ctrl
	import adsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	input  logic [ACT_W-1:0]         in_action,
	output logic                     in_ready,
	input  logic                     out_free,
	output logic                     div_start,
	output logic signed [STEP_W-1:0] div_dividend,
	output logic [FRM_W-1:0]         div_divisor,
	input  logic                     div_done,
	input  logic signed [STEP_W-1:0] div_quot,
	output lane_ctl_t                lane_ctl,
	output logic [FACT_W-1:0]        factor,
	output out_ctl_t                 out_ctl
);

	state_t                    state_q, state_d;
	phase_t                    phase_q;
	logic [FRM_W-1:0]          elapsed_q;
	logic [FRM_W-1:0]          length_q;
	logic [LVL_W-1:0]          level_q;
	logic signed [STEP_W-1:0]  step_q;
	logic                      frame_q;
	logic [GPROD_W-1:0]        gprod_s1;
	logic [FACT_W-1:0]         factor_q;

	logic                      accept;
	logic [SUS_W-1:0]          sus_clip;
	logic [LVL_W-1:0]          sus30;
	logic signed [LVL_W+1:0]   lsum;
	logic [LVL_W-1:0]          lvl_clamp;
	logic [FRM_W-1:0]          elapsed_inc;
	logic                      advance;
	logic [LVL_W-1:0]          div_tgt;
	logic [LVL_W-1:0]          div_base;
	logic [GPROD_W-1:0]        gsum;

	assign accept      = in_valid && in_ready;
	assign sus_clip    = (cfg.sus_level > SUS_ONE) ? SUS_ONE : cfg.sus_level;
	assign sus30       = {sus_clip, 15'd0};
	assign lsum        = $signed({2'b00, level_q}) + $signed({step_q[STEP_W-1], step_q});
	assign elapsed_inc = (elapsed_q != FRM_MAX) ? elapsed_q + FRM_W'(1) : elapsed_q;
	assign advance     = elapsed_inc > length_q;
	assign gsum        = gprod_s1 + GPROD_RND;

	always_comb begin
		if (lsum[LVL_W+1])
			lvl_clamp = LEVEL_ZERO;
		else if (lsum > $signed({2'b00, LEVEL_ONE}))
			lvl_clamp = LEVEL_ONE;
		else
			lvl_clamp = lsum[LVL_W-1:0];
	end

	// Ramp target and divisor for the step division
	always_comb begin
		div_tgt     = LEVEL_ONE;
		div_base    = level_q;
		div_divisor = cfg.attack_frames;
		if (state_q == ST_LEVEL) begin
			div_tgt     = sus30;
			div_base    = LEVEL_ONE;
			div_divisor = cfg.decay_frames;
		end else if (in_action == ACT_NOTE_OFF) begin
			div_tgt     = LEVEL_ZERO;
			div_divisor = cfg.release_frames;
		end
	end

	assign div_dividend = $signed({1'b0, div_tgt}) - $signed({1'b0, div_base});

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_action)
						ACT_FRAME:    state_d = ST_LEVEL;
						ACT_NOTE_ON:  state_d = (cfg.attack_frames != '0) ? ST_DIV : ST_IDLE;
						ACT_NOTE_OFF: state_d = (cfg.release_frames != '0) ? ST_DIV : ST_IDLE;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_LEVEL: state_d = div_start ? ST_DIV : ST_GAIN;
			ST_DIV: begin
				if (div_done)
					state_d = frame_q ? ST_GAIN : ST_IDLE;
			end
			ST_GAIN:  state_d = ST_FACT;
			ST_FACT:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready         = 1'b0;
		div_start        = 1'b0;
		lane_ctl.load    = 1'b0;
		lane_ctl.mul_en  = 1'b0;
		out_ctl.out_load = 1'b0;
		out_ctl.phase    = phase_q;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				lane_ctl.load = in_valid;
				if (in_valid) begin
					case (in_action)
						ACT_NOTE_ON:  div_start = cfg.attack_frames != '0;
						ACT_NOTE_OFF: div_start = cfg.release_frames != '0;
						default:      div_start = 1'b0;
					endcase
				end
			end
			ST_LEVEL: div_start = advance && (phase_q == PH_ATTACK) && (cfg.decay_frames != '0);
			ST_MUL:   lane_ctl.mul_en = 1'b1;
			ST_OUT:   out_ctl.out_load = out_free;
			default: begin
			end
		endcase
	end

	assign factor        = factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_SILENT;
			elapsed_q <= '0;
			length_q  <= '0;
			level_q   <= LEVEL_ZERO;
			step_q    <= '0;
			frame_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						frame_q <= in_action == ACT_FRAME;
						case (in_action)
							ACT_NOTE_ON: begin
								phase_q   <= PH_ATTACK;
								elapsed_q <= '0;
								length_q  <= cfg.attack_frames;
								if (cfg.attack_frames == '0) begin
									level_q <= LEVEL_ONE;
									step_q  <= '0;
								end
							end
							ACT_NOTE_OFF: begin
								phase_q   <= PH_RELEASE;
								elapsed_q <= '0;
								length_q  <= cfg.release_frames;
								if (cfg.release_frames == '0) begin
									level_q <= LEVEL_ZERO;
									step_q  <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LEVEL: begin
					level_q   <= lvl_clamp;
					elapsed_q <= elapsed_inc;
					if (advance) begin
						case (phase_q)
							PH_ATTACK: begin
								phase_q   <= PH_DECAY;
								elapsed_q <= '0;
								length_q  <= cfg.decay_frames;
								if (cfg.decay_frames == '0) begin
									level_q <= sus30;
									step_q  <= '0;
								end else begin
									level_q <= LEVEL_ONE;
								end
							end
							PH_DECAY: begin
								phase_q   <= PH_SUSTAIN;
								elapsed_q <= '0;
								length_q  <= '0;
								level_q   <= sus30;
								step_q    <= '0;
							end
							PH_RELEASE: begin
								phase_q   <= PH_SILENT;
								elapsed_q <= '0;
								length_q  <= '0;
								level_q   <= LEVEL_ZERO;
								step_q    <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done)
						step_q <= div_quot;
				end
				default: begin
				end
			endcase
		end
	end

	// Gain times level, then round to the Q4.16 factor
	always_ff @(posedge clk) begin
		if (state_q == ST_GAIN)
			gprod_s1 <= GPROD_W'(cfg.linear_gain) * GPROD_W'(level_q);
		if (state_q == ST_FACT)
			factor_q <= gsum[FACT_LSB+FACT_W-1:FACT_LSB];
	end

endmodule

// File: hdl/adsr_envelope_gain_top.sv
// ----------------------------------------------------------------------------
// adsr_envelope_gain_top
// Stereo ADSR envelope with linear output gain on a stream interface.
// ----------------------------------------------------------------------------
//
// Channel  Ports                 Payload (lowest bits first)
// -------  --------------------  -------------------------------------------
// in       s_axis_*              tuser: action; tdata: sample_left, sample_right
// out      m_axis_*              tuser: envelope_phase; tdata: out_left, out_right
// config   cfg_valid/ready/...   cfg_index: register, cfg_data: value
//
// A frame beat runs through the level, gain, factor, multiply and output
// states, and also waits in the divide state when it ends the attack phase
// with a nonzero decay length; a note beat waits there only with a nonzero
// ramp length. The serial step divider yields 31 quotient bits, one per
// cycle, then pulses done. The output register lets the next beat enter
// while a result waits. A stalled output holds the sequencer in its last
// state. Reset restores register defaults and a silent envelope at once.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_top
	import adsr_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
)
(
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// sample_left, sample_right
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// action
	input  logic [ACT_W-1:0]                       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// out_left, out_right
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
	// envelope_phase
	output logic [PH_W-1:0]                        m_axis_tuser,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [IDX_W-1:0]                       cfg_index,
	input  logic [CFG_W-1:0]                       cfg_data
);

	localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

	cfg_t                          cfg_q;
	lane_ctl_t                     lane_ctl;
	out_ctl_t                      out_ctl;
	logic [FACT_W-1:0]             factor;
	logic                          div_start;
	logic signed [STEP_W-1:0]      div_dividend;
	logic [FRM_W-1:0]              div_divisor;
	logic                          div_busy;
	logic                          div_done;
	logic signed [STEP_W-1:0]      div_quot;
	logic signed [SAMPLE_BITS-1:0] res_l;
	logic signed [SAMPLE_BITS-1:0] res_r;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_l_q;
	logic [SAMPLE_BITS-1:0]        out_r_q;
	phase_t                        out_ph_q;
	logic                          out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_frames  <= RST_ATTACK;
			cfg_q.decay_frames   <= RST_DECAY;
			cfg_q.sus_level      <= RST_SUSTAIN;
			cfg_q.release_frames <= RST_RELEASE;
			cfg_q.linear_gain    <= RST_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ATTACK:  cfg_q.attack_frames  <= cfg_data;
				REG_DECAY:   cfg_q.decay_frames   <= cfg_data;
				REG_SUSTAIN: cfg_q.sus_level      <= cfg_data[SUS_W-1:0];
				REG_RELEASE: cfg_q.release_frames <= cfg_data;
				REG_GAIN:    cfg_q.linear_gain    <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	adsr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_axis_tvalid),
		.in_action    (s_axis_tuser),
		.in_ready     (s_axis_tready),
		.out_free     (out_free),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quot     (div_quot),
		.lane_ctl     (lane_ctl),
		.factor       (factor),
		.out_ctl      (out_ctl)
	);

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	adsr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
		.clk       (clk),
		.ctl       (lane_ctl),
		.sample_in (s_axis_tdata[SAMPLE_BITS-1:0]),
		.factor    (factor),
		.result    (res_l)
	);

	adsr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
		.clk       (clk),
		.ctl       (lane_ctl),
		.sample_in (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.factor    (factor),
		.result    (res_r)
	);

	// Merge both lanes and the phase into one output beat
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_ctl.out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ctl.out_load) begin
			out_l_q  <= res_l;
			out_r_q  <= res_r;
			out_ph_q <= out_ctl.phase;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'({out_r_q, out_l_q});
	assign m_axis_tuser  = out_ph_q;

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_ctl.out_load && m_axis_tvalid && !m_axis_tready))
		else $error("output beat overwritten while stalled");

	// No input beat is taken while a step division runs
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_busy)
		else $error("input ready during step division");

	// A note-on with a nonzero attack length starts the divider
	a_note_on_div: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_NOTE_ON)
			&& (cfg_q.attack_frames != '0)) |=> div_busy)
		else $error("note-on did not start the step division");

endmodule

// File: sim/adsr_envelope_gain_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_gain_checker
// Watches the sample, result and register channels of the ADSR envelope
// block. Tracks the envelope in its own copy and compares every result beat
// against the oldest predicted frame.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_checker
	import adsr_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
)
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic [ACT_W-1:0]                   s_axis_tuser,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	input  logic [PH_W-1:0]                    m_axis_tuser,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [IDX_W-1:0]                   cfg_index,
	input  logic [CFG_W-1:0]                   cfg_data,
	output int                                 errors,
	output int                                 pending
);

	localparam longint LVL_ONE = longint'(1) << 30;

	typedef struct {
		logic [SAMPLE_BITS-1:0] left;
		logic [SAMPLE_BITS-1:0] right;
		phase_t                 ph;
	} frame_out_t;

	frame_out_t frames_due[$];

	// Register copy
	logic [FRM_W-1:0]  atk_len;
	logic [FRM_W-1:0]  dec_len;
	logic [FRM_W-1:0]  rel_len;
	logic [SUS_W-1:0]  sus_set;
	logic [GAIN_W-1:0] gain_set;

	// Envelope copy
	phase_t           env_phase;
	logic [FRM_W-1:0] frames_done;
	logic [FRM_W-1:0] ramp_len;
	longint           level;
	longint           step;

	function automatic longint sustain_target();
		if (sus_set > SUS_ONE)
			return longint'(SUS_ONE) << 15;
		return longint'(sus_set) << 15;
	endfunction

	function automatic void begin_ramp(phase_t ph, logic [FRM_W-1:0] len, longint target);
		env_phase   = ph;
		frames_done = '0;
		ramp_len    = len;
		if (len == 0) begin
			level = target;
			step  = 0;
		end else begin
			step = (target - level) / longint'(len);
		end
	endfunction

	// Round to nearest (ties up) and saturate to the sample range
	function automatic logic [SAMPLE_BITS-1:0] scale_sample(
		logic signed [SAMPLE_BITS-1:0] smp, longint fac);
		longint acc;
		longint maxv;
		maxv = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		acc  = (longint'(smp) * fac + 32768) >>> 16;
		if (acc > maxv)
			acc = maxv;
		if (acc < -maxv - 1)
			acc = -maxv - 1;
		return acc[SAMPLE_BITS-1:0];
	endfunction

	function automatic frame_out_t predict_frame(logic [SAMPLE_BITS-1:0] l,
		logic [SAMPLE_BITS-1:0] r);
		frame_out_t res;
		longint     fac;
		level = level + step;
		if (level < 0)
			level = 0;
		if (level > LVL_ONE)
			level = LVL_ONE;
		if (frames_done < FRM_MAX)
			frames_done = frames_done + 1'b1;
		if (frames_done > ramp_len) begin
			case (env_phase)
				PH_ATTACK: begin
					level = LVL_ONE;
					begin_ramp(PH_DECAY, dec_len, sustain_target());
				end
				PH_DECAY: begin
					env_phase   = PH_SUSTAIN;
					frames_done = '0;
					ramp_len    = '0;
					level       = sustain_target();
					step        = 0;
				end
				PH_RELEASE: begin
					env_phase   = PH_SILENT;
					frames_done = '0;
					ramp_len    = '0;
					level       = 0;
					step        = 0;
				end
				default: ;
			endcase
		end
		fac       = (longint'(gain_set) * level + (longint'(1) << 25)) >>> 26;
		res.left  = scale_sample(l, fac);
		res.right = scale_sample(r, fac);
		res.ph    = env_phase;
		return res;
	endfunction

	function automatic int field_diff(string name, longint want, longint got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_out_t want;
		if (!arst_n) begin
			atk_len     = RST_ATTACK;
			dec_len     = RST_DECAY;
			sus_set     = RST_SUSTAIN;
			rel_len     = RST_RELEASE;
			gain_set    = RST_GAIN;
			env_phase   = PH_SILENT;
			frames_done = '0;
			ramp_len    = '0;
			level       = 0;
			step        = 0;
			frames_due.delete();
			errors      = 0;
			pending     = 0;
		end else begin
			// Compare before predicting: a result never belongs to the beat
			// accepted on the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (frames_due.size() == 0) begin
					$error("result beat with no frame waiting: tdata %h tuser %0d",
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want   = frames_due.pop_front();
					errors += field_diff("out_left", $signed(want.left),
						$signed(m_axis_tdata[SAMPLE_BITS-1:0]));
					errors += field_diff("out_right", $signed(want.right),
						$signed(m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
					errors += field_diff("envelope_phase", want.ph, m_axis_tuser);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTACK:  atk_len  = cfg_data[FRM_W-1:0];
					REG_DECAY:   dec_len  = cfg_data[FRM_W-1:0];
					REG_SUSTAIN: sus_set  = cfg_data[SUS_W-1:0];
					REG_RELEASE: rel_len  = cfg_data[FRM_W-1:0];
					REG_GAIN:    gain_set = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					ACT_FRAME:    frames_due.push_back(predict_frame(
						s_axis_tdata[SAMPLE_BITS-1:0],
						s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
					ACT_NOTE_ON:  begin_ramp(PH_ATTACK, atk_len, LVL_ONE);
					ACT_NOTE_OFF: begin_ramp(PH_RELEASE, rel_len, 0);
					default: ;
				endcase
			end
			pending = frames_due.size();
		end
	end

endmodule

// File: sim/adsr_envelope_gain_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_gain_top_tb
// Drives note, frame and spare-code beats with bursty timing against a
// stalling result sink, steps through several envelope and gain settings,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_top_tb;
	import adsr_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int LIMIT       = 1000000;
	localparam int DRAIN       = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_ITEMS  = 1050;
	localparam int PHASES      = 10;

	localparam logic [ACT_W-1:0]       ACT_SPARE = 2'd3;
	localparam logic [SAMPLE_BITS-1:0] SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic [ACT_W-1:0]  s_axis_tuser  = ACT_FRAME;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic [PH_W-1:0]   m_axis_tuser;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index     = REG_ATTACK;
	logic [CFG_W-1:0]  cfg_data      = '0;

	logic              hold_go       = 1'b0;
	int                errors;
	int                pending;
	int                cycle_cnt     = 0;
	int                burst_left    = 0;
	int                sent          = 0;

	logic [FRM_W-1:0]  atk;
	logic [FRM_W-1:0]  dec;
	logic [FRM_W-1:0]  rel;
	logic [SUS_W-1:0]  sus;
	logic [GAIN_W-1:0] gain;

	adsr_envelope_gain_top #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	adsr_envelope_gain_checker #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("FAIL adsr_envelope_gain_top");
			$finish;
		end
	end

	// Result sink: stall on a pattern that changes mode every so often, and
	// hold off once for a long stretch so the block backs up into its input
	initial begin : rx_side
		rx_mode_t mode;
		int       mode_left;
		bit       hold_done;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 120);
			end
			mode_left--;
			case (mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
				default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return SMP_MIN;
		if (r == 1)
			return SMP_MAX;
		if (r == 2)
			return '0;
		return SAMPLE_BITS'($urandom);
	endfunction

	// Mostly short ramps so every phase change shows up often
	function automatic logic [FRM_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return FRM_W'($urandom);
		if (r < 5)
			return FRM_W'($urandom_range(0, 1));
		return FRM_W'($urandom_range(2, 24));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	// Valid stays high between beats of one burst.
	task automatic drive_beat(input logic [ACT_W-1:0] act,
		input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 45);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= DATA_W'({r, l});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (act != ACT_SPARE)
			sent++;
	endtask

	// Drop valid, wait for every frame result, then let note beats finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] d,
		input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] g);
		settle();
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_RELEASE, rl);
		write_reg(REG_GAIN, g);
		cfg_valid <= 1'b0;
		@(negedge clk);
		burst_left = 0;
	endtask

	initial begin : stimulus
		int  k;
		int  r;
		int  span;
		int  rspan;
		int  phase_end;
		bit  paused;
		paused = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short ramps, sustain above full scale, gain high enough to clip
		atk = 24'd2;
		dec = 24'd2;
		rel = 24'd3;
		apply_config(atk, dec, 24'd40000, rel, 24'd65535);
		drive_beat(ACT_NOTE_OFF, '0, '0);
		drive_beat(ACT_FRAME, SMP_MAX, SMP_MIN);
		drive_beat(ACT_SPARE, SMP_MIN, SMP_MAX);
		drive_beat(ACT_NOTE_ON, '0, '0);
		for (k = 0; k < 8; k++)
			drive_beat(ACT_FRAME, k[0] ? SMP_MIN : SMP_MAX, k[1] ? '1 : SMP_MAX);
		drive_beat(ACT_NOTE_OFF, '0, '0);
		for (k = 0; k < 5; k++)
			drive_beat(ACT_FRAME, k[0] ? SMP_MAX : SMP_MIN, '0);

		// Zero ramp lengths jump straight to each target
		apply_config('0, '0, '0, '0, 24'(RST_GAIN));
		drive_beat(ACT_NOTE_ON, '0, '0);
		drive_beat(ACT_FRAME, SMP_MAX, SMP_MIN);
		drive_beat(ACT_FRAME, SMP_MIN, SMP_MAX);
		drive_beat(ACT_NOTE_OFF, '0, '0);
		drive_beat(ACT_FRAME, SMP_MAX, SMP_MAX);

		for (k = 0; k < PHASES; k++) begin
			if (k == 0) begin
				atk  = '1;
				dec  = '1;
				rel  = '1;
				sus  = SUS_ONE;
				gain = '1;
			end else if (k == 1) begin
				atk  = '0;
				dec  = '0;
				rel  = '0;
				sus  = '0;
				gain = '0;
			end else begin
				atk  = pick_len();
				dec  = pick_len();
				rel  = pick_len();
				sus  = ($urandom_range(0, 3) == 0) ? SUS_W'($urandom) :
					SUS_W'($urandom_range(0, 32768));
				gain = ($urandom_range(0, 3) == 0) ? RST_GAIN : GAIN_W'($urandom);
				if (k == 2)
					sus = '1;
			end
			apply_config(atk, dec, {8'($urandom), sus}, rel, {8'($urandom), gain});
			if (k == 4)
				hold_go <= 1'b1;
			span = int'(atk) + int'(dec) + 4;
			if (span > 40 || span < 0)
				span = 40;
			rspan = int'(rel) + 3;
			if (rspan > 40 || rspan < 0)
				rspan = 40;
			phase_end = sent + RAND_ITEMS / PHASES;
			while (sent < phase_end) begin
				if (k == 6 && !paused && sent > phase_end - 50) begin
					paused = 1'b1;
					s_axis_tvalid <= 1'b0;
					@(negedge clk);
					while (pending != 0)
						@(negedge clk);
					burst_left = 0;
				end
				r = $urandom_range(0, 9);
				if (r < 7) begin
					drive_beat(ACT_NOTE_ON, rand_sample(), rand_sample());
					repeat ($urandom_range(0, span))
						drive_beat(ACT_FRAME, rand_sample(), rand_sample());
					// Now and then leave the note held into the next one
					if (r != 0)
						drive_beat(ACT_NOTE_OFF, rand_sample(), rand_sample());
					repeat ($urandom_range(0, rspan))
						drive_beat(ACT_FRAME, rand_sample(), rand_sample());
				end else if (r == 7) begin
					drive_beat(ACT_NOTE_ON, rand_sample(), rand_sample());
					repeat ($urandom_range(0, 3))
						drive_beat(ACT_FRAME, rand_sample(), rand_sample());
					drive_beat(ACT_NOTE_ON, rand_sample(), rand_sample());
					repeat ($urandom_range(0, span))
						drive_beat(ACT_FRAME, rand_sample(), rand_sample());
				end else if (r == 8) begin
					repeat ($urandom_range(1, 4))
						drive_beat(ACT_W'($urandom_range(0, 3)), rand_sample(),
							rand_sample());
				end else begin
					repeat ($urandom_range(3, 20))
						drive_beat(ACT_FRAME, rand_sample(), rand_sample());
				end
			end
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("PASS adsr_envelope_gain_top");
		else
			$display("FAIL adsr_envelope_gain_top");
		$finish;
	end

endmodule
